FILE: sv/positional_list_insert_remove_unit_defines.svh
`ifndef POSITIONAL_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define POSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define POSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/posl_pkg.sv
`default_nettype none

package posl_pkg;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_END   = 3'd1;
    localparam logic [2:0] OP_INS_AT    = 3'd2;
    localparam logic [2:0] OP_REM_FRONT = 3'd3;
    localparam logic [2:0] OP_REM_END   = 3'd4;
    localparam logic [2:0] OP_REM_AT    = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // leaves per first-level group of the removed-entry gather tree
    localparam int GATHER_GROUP = 16;

    typedef struct packed {
        logic [2:0]  operation;
        logic [8:0]  position;
        logic [31:0] entry_value;
    } t_in_word;

    typedef struct packed {
        logic [31:0] removed_value;
        logic [1:0]  status;
        logic [8:0]  entry_count;
    } t_out_word;

    // per-request shift command broadcast along the row of cells
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: sv/posl_cell.sv
`default_nettype none

module posl_cell
    import posl_pkg::*;
#(
    parameter int EW   = 32,
    parameter int CMPW = 9,
    parameter int IDX  = 0
) (
    input  wire logic            i_clk,
    input  wire t_cell_ctl       i_ctl,
    input  wire logic [CMPW-1:0] i_at,
    input  wire logic [EW-1:0]   i_new,
    input  wire logic [EW-1:0]   i_left,
    input  wire logic [EW-1:0]   i_right,
    output logic      [EW-1:0]   o_slot,
    output logic      [EW-1:0]   o_pick
);

    localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

    logic [EW-1:0] r_slot;
    logic [EW-1:0] n_slot;
    logic          hit;
    logic          above;

    assign hit   = (i_at == MY_IDX);
    assign above = (MY_IDX > i_at);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins) begin
            if (above) begin
                n_slot = i_left;
            end else if (hit) begin
                n_slot = i_new;
            end
        end else if (i_ctl.rem) begin
            if (above || hit) begin
                n_slot = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;
    // value leaving the list, taken before the shift lands
    assign o_pick = (i_ctl.rem && hit) ? r_slot : '0;

endmodule

`default_nettype wire

FILE: sv/posl_gather.sv
`default_nettype none

module posl_gather
    import posl_pkg::*;
#(
    parameter int EW       = 32,
    parameter int CAPACITY = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic [CAPACITY-1:0][EW-1:0]  i_picks,
    output logic      [EW-1:0]                o_value
);

    localparam int NG = (CAPACITY + GATHER_GROUP - 1) / GATHER_GROUP;

    logic [NG-1:0][EW-1:0] r_grp;
    logic [NG-1:0][EW-1:0] n_grp;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GATHER_GROUP; k++) begin
                if (g * GATHER_GROUP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_picks[g * GATHER_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_value = '0;
        for (int g = 0; g < NG; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule

`default_nettype wire

FILE: sv/positional_list_insert_remove_unit.sv
// positional list: an ordered list of up to CAPACITY entry words
//
// input channel (i_in_valid / o_in_ready, word i_in_word) carries one request:
// insert at front, end or a position, or remove from front, end or a position
// output channel (o_out_valid / i_out_ready, word o_out_word) returns one word
// per request: removed entry (zero unless a remove succeeded), status and the
// entry count after the request
// each cell of the row holds one slot; an accepted request makes every cell
// take its left neighbour, its right neighbour, the new entry or keep its own,
// all in the accept cycle, so the next request already sees the new list
// the removed entry is collected through a two-level or-tree whose first
// level is registered; results pass the gather stage and the output register
// throughput: one request per cycle while the receiver keeps up; the output
// register and the gather stage part the two sides
// when the receiver stalls, one result waits in the output register and one
// in the gather stage; then o_in_ready drops until the receiver takes a word
// reset (i_rst_n low, synchronous) empties the list and drops both valids;
// slot contents are not cleared, there is no clearing pass
`default_nettype none

`include "positional_list_insert_remove_unit_defines.svh"

module positional_list_insert_remove_unit
    import posl_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int EW   = ENTRY_WIDTH;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    localparam logic [CMPW-1:0] CAP_W = CMPW'(CAPACITY);

    // list occupancy
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    // gather stage and output register
    logic            r_s1_valid;
    logic [1:0]      r_s1_status;
    logic [8:0]      r_s1_count;
    logic            r_out_valid;
    t_out_word       r_out_word;

    logic            accept;
    logic            s1_adv;
    logic [2:0]      op;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] at_ins;
    logic [CMPW-1:0] at_rem;
    logic [CMPW-1:0] at;
    logic            is_ins;
    logic            is_rem;
    logic            full;
    logic            empty;
    logic            ins_ok;
    logic            rem_ok;
    logic [1:0]      status;
    t_cell_ctl       ctl;
    logic [EW-1:0]   new_val;
    logic [EW-1:0]   removed;

    logic [CAPACITY-1:0][EW-1:0] slot;
    logic [CAPACITY-1:0][EW-1:0] pick;

    assign op     = i_in_word.operation;
    assign cnt_w  = CMPW'(r_count);
    assign pos_w  = CMPW'(i_in_word.position);
    assign full   = (cnt_w == CAP_W);
    assign empty  = (r_count == '0);

    always_comb begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        at_ins = pos_w;
        at_rem = pos_w;
        unique case (op)
            OP_INS_FRONT: begin
                is_ins = 1'b1;
                at_ins = '0;
            end
            OP_INS_END: begin
                is_ins = 1'b1;
                at_ins = cnt_w;
            end
            OP_INS_AT: begin
                is_ins = 1'b1;
            end
            OP_REM_FRONT: begin
                is_rem = 1'b1;
                at_rem = '0;
            end
            OP_REM_END: begin
                is_rem = 1'b1;
                at_rem = cnt_w - CMPW'(1);
            end
            OP_REM_AT: begin
                is_rem = 1'b1;
            end
            default: begin
                // unused codes leave the list alone and report ok
            end
        endcase
    end

    // full and empty take precedence over the position check
    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        status = ST_OK;
        if (is_ins) begin
            if (full) begin
                status = ST_FULL;
            end else if (at_ins > cnt_w) begin
                status = ST_RANGE;
            end else begin
                ins_ok = 1'b1;
            end
        end else if (is_rem) begin
            if (empty) begin
                status = ST_EMPTY;
            end else if (at_rem >= cnt_w) begin
                status = ST_RANGE;
            end else begin
                rem_ok = 1'b1;
            end
        end
    end

    assign at      = is_ins ? at_ins : at_rem;
    assign new_val = EW'(i_in_word.entry_value);

    // handshake: take a new word whenever the gather stage is free or moving on
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    assign ctl.ins = accept && ins_ok;
    assign ctl.rem = accept && rem_ok;

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    // row of cells, each handing its slot to both neighbours
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [EW-1:0] left_val;
        logic [EW-1:0] right_val;

        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_inner_l
            assign left_val = slot[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner_r
            assign right_val = slot[i+1];
        end

        posl_cell #(
            .EW   (EW),
            .CMPW (CMPW),
            .IDX  (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_at    (at),
            .i_new   (new_val),
            .i_left  (left_val),
            .i_right (right_val),
            .o_slot  (slot[i]),
            .o_pick  (pick[i])
        );
    end

    // removed entry, first tree level registered at accept
    posl_gather #(
        .EW       (EW),
        .CAPACITY (CAPACITY)
    ) u_gather (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_picks (pick),
        .o_value (removed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= status;
            r_s1_count  <= 9'(n_count);
        end
        if (s1_adv) begin
            r_out_word.removed_value <= 32'(removed);
            r_out_word.status        <= r_s1_status;
            r_out_word.entry_count   <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `POSL_ASSERT_NOW(a_count_bound, 1'b1, cnt_w <= CAP_W, "entry count above capacity")
    `POSL_ASSERT_NEXT(a_ins_grows, ctl.ins, r_count == $past(r_count) + CW'(1), "insert did not grow count")
    `POSL_ASSERT_NEXT(a_rem_shrinks, ctl.rem, r_count == $past(r_count) - CW'(1), "remove did not shrink count")
    `POSL_ASSERT_NOW(a_stall_blocks, r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready, "input open with both stages held")
    `POSL_ASSERT_NEXT(a_adv_shows, s1_adv, r_out_valid, "advanced result not shown")

endmodule

`default_nettype wire
